/* design/fhm_pkg.sv */
package fhm_pkg;

  localparam int unsigned TASK_W = 4;

  typedef enum logic [1:0] {
    REQ_LOCK   = 2'd0,
    REQ_UNLOCK = 2'd1,
    REQ_TRY    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_ACQUIRED = 3'd0,
    ST_ALREADY  = 3'd1,
    ST_PARKED   = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_FREED    = 3'd4,
    ST_HANDOFF  = 3'd5,
    ST_NOTASK   = 3'd6,
    ST_FULL     = 3'd7
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } fhm_cmd_t;

endpackage

/* design/fhm_ctrl.sv */
module fhm_ctrl
  import fhm_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output fhm_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CTRL_IDLE: begin
        if (start) state_d = CTRL_EXEC;
      end
      CTRL_EXEC: begin
        state_d = CTRL_IDLE;
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy  = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        cmd_o.capture = start;
      end
      CTRL_EXEC: begin
        cmd_o.execute = 1'b1;
        busy          = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* design/fhm_dp.sv */
module fhm_dp
  import fhm_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fhm_cmd_t          cmd_i,
  input  logic [1:0]        req_type_i,
  input  logic              task_present_i,
  input  logic [TASK_W-1:0] task_id_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic              wake_valid_o,
  output logic [TASK_W-1:0] wake_task_o,
  output logic              is_locked_o,
  output logic [TASK_W-1:0] owner_task_o
);

  localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TASKS);

  // waiter queue storage
  logic [TASK_W-1:0] mem_q [MAX_TASKS];
  logic [TASK_W-1:0] rd_q;

  logic [1:0]        req_q;
  logic              present_q;
  logic [TASK_W-1:0] tid_q;

  logic              locked_q, locked_d;
  logic [TASK_W-1:0] owner_q, owner_d;
  logic [IDX_W-1:0]  head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic              push;
  status_e           status_d;
  logic              wake_v_d;
  logic [TASK_W-1:0] wake_t_d;

  logic              done_q;
  logic [2:0]        status_q;
  logic              wake_v_q;
  logic [TASK_W-1:0] wake_t_q;
  logic              lock_out_q;
  logic [TASK_W-1:0] owner_out_q;

  always_comb begin
    locked_d = locked_q;
    owner_d  = owner_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    push     = 1'b0;
    wake_v_d = 1'b0;
    wake_t_d = '0;
    status_d = ST_REFUSED;
    priority if (!present_q) begin
      status_d = ST_NOTASK;
    end else if (req_q == REQ_LOCK || req_q == REQ_TRY) begin
      priority if (!locked_q) begin
        locked_d = 1'b1;
        owner_d  = tid_q;
        status_d = ST_ACQUIRED;
      end else if (owner_q == tid_q) begin
        status_d = ST_ALREADY;
      end else if (req_q == REQ_TRY) begin
        status_d = ST_REFUSED;
      end else if (count_q == FULL_CNT) begin
        status_d = ST_FULL;
      end else begin
        push     = 1'b1;
        tail_d   = (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
        count_d  = count_q + 1'b1;
        status_d = ST_PARKED;
      end
    end else if (req_q == REQ_UNLOCK) begin
      priority if (!locked_q || owner_q != tid_q) begin
        status_d = ST_REFUSED;
      end else if (count_q != '0) begin
        head_d   = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
        count_d  = count_q - 1'b1;
        owner_d  = rd_q;
        wake_v_d = 1'b1;
        wake_t_d = rd_q;
        status_d = ST_HANDOFF;
      end else begin
        locked_d = 1'b0;
        owner_d  = '0;
        status_d = ST_FREED;
      end
    end else begin
      status_d = ST_REFUSED;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q     <= req_type_i;
      present_q <= task_present_i;
      tid_q     <= task_id_i;
      rd_q      <= mem_q[head_q];
    end
    if (cmd_i.execute && push) begin
      mem_q[tail_q] <= tid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      locked_q    <= 1'b0;
      owner_q     <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      status_q    <= '0;
      wake_v_q    <= 1'b0;
      wake_t_q    <= '0;
      lock_out_q  <= 1'b0;
      owner_out_q <= '0;
    end else begin
      done_q <= cmd_i.execute;
      if (cmd_i.execute) begin
        locked_q    <= locked_d;
        owner_q     <= owner_d;
        head_q      <= head_d;
        tail_q      <= tail_d;
        count_q     <= count_d;
        status_q    <= status_d;
        wake_v_q    <= wake_v_d;
        wake_t_q    <= wake_t_d;
        lock_out_q  <= locked_d;
        owner_out_q <= locked_d ? owner_d : '0;
      end
    end
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign wake_valid_o = wake_v_q;
  assign wake_task_o  = wake_t_q;
  assign is_locked_o  = lock_out_q;
  assign owner_task_o = owner_out_q;

endmodule

/* design/fifo_handoff_mutex.sv */
// at acceptance the request and the queue head are captured into registers and the controller
// enters its decision state, in which the result is written to the output registers that
// drive done_o; a new transaction is not taken while busy, since the registered read of the
// queue head is followed by the single decision state
// the result is shown for one cycle with done_o; the receiver cannot stall
// reset: asynchronous, active low; mutex free, queue empty, queue storage left unset
module fifo_handoff_mutex
  import fhm_pkg::*;
#(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic        task_present_i,
  input  logic [3:0]  task_id_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        wake_valid_o,
  output logic [3:0]  wake_task_o,
  output logic        is_locked_o,
  output logic [3:0]  owner_task_o
);

  fhm_cmd_t cmd;

  fhm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  fhm_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .req_type_i     (req_type_i),
    .task_present_i (task_present_i),
    .task_id_i      (task_id_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .wake_valid_o   (wake_valid_o),
    .wake_task_o    (wake_task_o),
    .is_locked_o    (is_locked_o),
    .owner_task_o   (owner_task_o)
  );

  a_busy_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o && !busy)
    else $error("decision cycle did not end in a result");

  a_accept_to_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && cmd.execute)
    else $error("accepted transaction not executed");

  a_wake_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && wake_valid_o |-> status_o == ST_HANDOFF && is_locked_o)
    else $error("wakeup without handoff");

  a_free_no_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !is_locked_o |-> owner_task_o == '0 && !wake_valid_o)
    else $error("owner reported while unlocked");

endmodule
